### src/adep_pkg.sv
package adep_pkg;

  localparam int MAX_LAYERS = 64;
  localparam int IDX_W      = $clog2(MAX_LAYERS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int LAYER_W    = 6;

  localparam int DIV_W      = 56;
  localparam int DVS_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [31:0] EXP_NEG1  = 32'd1580030169;
  localparam logic [31:0] EXP_POS1  = 32'd2918732888;
  localparam logic [23:0] W_MAX     = 24'hFFFFFF;
  localparam logic [31:0] EFOLD_RST = 32'd6554;
  localparam logic [19:0] SHARE_RST = 20'd32768;
  localparam logic [3:0]  EXP_TERMS = 4'd13;

  // Configuration register indexes.
  localparam logic [2:0] CFG_EFOLD = 3'd0;
  localparam logic [2:0] CFG_NORM  = 3'd1;
  localparam logic [2:0] CFG_LSHR  = 3'd2;
  localparam logic [2:0] CFG_RSHR  = 3'd3;
  localparam logic [2:0] CFG_RPRES = 3'd4;
  localparam logic [2:0] CFG_LPRES = 3'd5;
  localparam logic [2:0] CFG_FPRES = 3'd6;

  // Multiplier operand selects.
  localparam logic [3:0] MUL_TERM  = 4'd0;
  localparam logic [3:0] MUL_PEXP  = 4'd1;
  localparam logic [3:0] MUL_WHOLE = 4'd2;
  localparam logic [3:0] MUL_BH    = 4'd3;
  localparam logic [3:0] MUL_BL    = 4'd4;
  localparam logic [3:0] MUL_MH    = 4'd5;
  localparam logic [3:0] MUL_ML    = 4'd6;
  localparam logic [3:0] MUL_LH    = 4'd7;
  localparam logic [3:0] MUL_LL    = 4'd8;
  localparam logic [3:0] MUL_FH    = 4'd9;
  localparam logic [3:0] MUL_FL    = 4'd10;

  // Divider operand selects.
  localparam logic [2:0] DIV_RATIO = 3'd0;
  localparam logic [2:0] DIV_EXP   = 3'd1;
  localparam logic [2:0] DIV_SHL   = 3'd2;
  localparam logic [2:0] DIV_SHR   = 3'd3;
  localparam logic [2:0] DIV_NORM  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       phase;
    logic       div_go;
    logic [2:0] div_sel;
    logic [3:0] mul_sel;
    logic       exp_init;
    logic       exp_acc;
    logic       exp_end;
    logic       pexp_wb;
    logic       whole_wb;
    logic       set_a;
    logic       set_w;
    logic       clr_w;
    logic       store;
    logic       sh_zero;
    logic       set_lf;
    logic       set_rf;
    logic       rd;
    logic       w_raw;
    logic       w_div;
    logic       acc_hi;
    logic       acc_lo;
    logic       set_lm;
    logic       set_rc;
    logic       sh_hi;
    logic       set_lc;
    logic       set_fc;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic zero_w;
    logic div_done;
    logic k_last;
    logic whole_go;
    logic a_zero;
    logic last;
    logic tot_zero;
    logic norm_go;
    logic out_last;
  } sts_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sh0_7FFF_FFFF_FFFF;
    lo = -hi - 50'sd1;
    if (v > hi) begin
      return hi[47:0];
    end else if (v < lo) begin
      return lo[47:0];
    end
    return v[47:0];
  endfunction

endpackage

### src/adep_div.sv
module adep_div
  import adep_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DVS_W:0]       sh;
  logic [DVS_W:0]       diff;
  logic                 ge;

  // One quotient bit per cycle, restoring.
  assign sh   = {rem_q, quo_q[DIV_W-1]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### src/adep_dp.sv
module adep_dp
  import adep_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  surface_level_i,
  input  logic signed [31:0]  layer_top_level_i,
  input  logic signed [31:0]  layer_depth_span_i,
  input  logic signed [47:0]  root_mass_now_i,
  input  logic signed [47:0]  standing_biomass_i,
  input  logic signed [47:0]  mortality_flux_i,
  input  logic                final_layer_i,
  output logic [LAYER_W-1:0]  layer_number_o,
  output logic signed [47:0]  root_change_o,
  output logic signed [47:0]  labile_change_o,
  output logic signed [47:0]  refractory_change_o,
  output logic                run_end_o
);

  // Configuration registers.
  logic [31:0] efold_q;
  logic        norm_q;
  logic [19:0] lshare_q;
  logic [19:0] rshare_q;
  logic        rpres_q;
  logic        lpres_q;
  logic        fpres_q;

  // Captured word.
  logic signed [31:0] surf_q, top_q, span_q;
  logic signed [47:0] mass_q, bio_q, mort_q;
  logic               last_q;

  // Weight evaluation.
  logic [31:0]        g_q;
  logic [31:0]        n_q;
  logic [32:0]        term_q;
  logic signed [35:0] sum_q;
  logic [3:0]         k_q;
  logic               neg_q;
  logic [33:0]        acc_q;
  logic [32:0]        a_q;
  logic [23:0]        w_q;
  logic [67:0]        prod_q;

  // Column state and result assembly.
  logic [CNT_W-1:0]   loaded_q;
  logic [31:0]        total_q;
  logic [CNT_W-1:0]   i_q;
  logic [16:0]        lf_q, rf_q;
  logic [23:0]        w_rd_q;
  logic signed [47:0] m_rd_q;
  logic [48:0]        r_q;
  logic [47:0]        lm_q;
  logic signed [47:0] rc_q, lc_q, fc_q;

  logic [23:0]        wmem [MAX_LAYERS];
  logic signed [47:0] mmem [MAX_LAYERS];

  logic signed [32:0] td;
  logic [32:0]        td_neg;
  logic [31:0]        td_mag;
  logic [47:0]        bio_mag, mort_mag;
  logic [33:0]        clampv;
  logic [33:0]        opa, opb;
  logic [DIV_W-1:0]   dividend;
  logic [DVS_W-1:0]   divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quot;
  logic [20:0]        tot;
  logic signed [35:0] qext;
  logic [32:0]        total_sum;
  logic [48:0]        r_lo_sum;
  logic [48:0]        s_sum;
  logic signed [49:0] rsig, rc_diff, s_sig;

  assign td      = {surf_q[31], surf_q} - {top_q[31], top_q};
  assign td_neg  = 33'(-td);
  assign td_mag  = td[32] ? td_neg[31:0] : td[31:0];
  assign bio_mag  = bio_q[47]  ? 48'(-bio_q)  : 48'(bio_q);
  assign mort_mag = mort_q[47] ? 48'(-mort_q) : 48'(mort_q);
  assign tot     = {1'b0, lshare_q} + {1'b0, rshare_q};
  assign qext    = $signed({3'b000, quot[32:0]});

  // Series result clamped to its valid range.
  always_comb begin
    if (sum_q < 0) begin
      clampv = '0;
    end else if (neg_q && (sum_q > 36'sh1_0000_0000)) begin
      clampv = 34'h1_0000_0000;
    end else begin
      clampv = sum_q[33:0];
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_TERM: begin
        opa = 34'(term_q);
        opb = 34'(g_q);
      end
      MUL_PEXP: begin
        opa = 34'(a_q[32:2]);
        opb = clampv;
      end
      MUL_WHOLE: begin
        opa = acc_q;
        opb = neg_q ? 34'(EXP_NEG1) : 34'(EXP_POS1);
      end
      MUL_BH: begin
        opa = 34'(bio_mag[47:24]);
        opb = 34'(w_q);
      end
      MUL_BL: begin
        opa = 34'(bio_mag[23:0]);
        opb = 34'(w_q);
      end
      MUL_MH: begin
        opa = 34'(mort_mag[47:24]);
        opb = 34'(w_q);
      end
      MUL_ML: begin
        opa = 34'(mort_mag[23:0]);
        opb = 34'(w_q);
      end
      MUL_LH: begin
        opa = 34'(lm_q[47:24]);
        opb = 34'(lf_q);
      end
      MUL_LL: begin
        opa = 34'(lm_q[23:0]);
        opb = 34'(lf_q);
      end
      MUL_FH: begin
        opa = 34'(lm_q[47:24]);
        opb = 34'(rf_q);
      end
      MUL_FL: begin
        opa = 34'(lm_q[23:0]);
        opb = 34'(rf_q);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_RATIO: begin
        dividend = {(cmd_i.phase ? td_mag : span_q[31:0]), 24'h0};
        divisor  = efold_q;
      end
      DIV_EXP: begin
        dividend = DIV_W'(prod_q[64:32]);
        divisor  = DVS_W'(k_q);
      end
      DIV_SHL: begin
        dividend = DIV_W'({lshare_q, 16'h0});
        divisor  = DVS_W'(tot);
      end
      DIV_SHR: begin
        dividend = DIV_W'({rshare_q, 16'h0});
        divisor  = DVS_W'(tot);
      end
      DIV_NORM: begin
        dividend = DIV_W'({w_rd_q, 24'h0});
        divisor  = total_q;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  adep_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      efold_q  <= EFOLD_RST;
      norm_q   <= 1'b1;
      lshare_q <= SHARE_RST;
      rshare_q <= SHARE_RST;
      rpres_q  <= 1'b1;
      lpres_q  <= 1'b1;
      fpres_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EFOLD: efold_q  <= cfg_data_i;
        CFG_NORM:  norm_q   <= cfg_data_i[0];
        CFG_LSHR:  lshare_q <= cfg_data_i[19:0];
        CFG_RSHR:  rshare_q <= cfg_data_i[19:0];
        CFG_RPRES: rpres_q  <= cfg_data_i[0];
        CFG_LPRES: lpres_q  <= cfg_data_i[0];
        CFG_FPRES: fpres_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign total_sum = {1'b0, total_q} + 33'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      total_q  <= '0;
      i_q      <= '0;
    end else begin
      if (cmd_i.store) begin
        loaded_q <= loaded_q + 1'b1;
        total_q  <= total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
      end
      if (cmd_i.advance) begin
        if (sts_o.out_last) begin
          loaded_q <= '0;
          total_q  <= '0;
          i_q      <= '0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      wmem[loaded_q[IDX_W-1:0]] <= w_q;
      mmem[loaded_q[IDX_W-1:0]] <= mass_q;
    end
    if (cmd_i.rd) begin
      w_rd_q <= wmem[i_q[IDX_W-1:0]];
      m_rd_q <= mmem[i_q[IDX_W-1:0]];
    end
  end

  assign r_lo_sum = r_q + 49'(prod_q[47:24]);
  assign s_sum    = r_q + 49'(prod_q[40:16]);
  assign rsig     = bio_q[47] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
  assign rc_diff  = rsig - 50'(m_rd_q);
  assign s_sig    = mort_q[47] ? -$signed({1'b0, s_sum}) : $signed({1'b0, s_sum});

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (cmd_i.load) begin
      surf_q <= surface_level_i;
      top_q  <= layer_top_level_i;
      span_q <= layer_depth_span_i;
      mass_q <= root_mass_now_i;
      bio_q  <= standing_biomass_i;
      mort_q <= mortality_flux_i;
      last_q <= final_layer_i;
    end
    if (cmd_i.exp_init) begin
      g_q    <= {quot[23:0], 8'h0};
      n_q    <= quot[55:24];
      term_q <= 33'h1_0000_0000;
      sum_q  <= 36'sh1_0000_0000;
      k_q    <= 4'd1;
      neg_q  <= cmd_i.phase ? ~td[32] : 1'b1;
    end
    if (cmd_i.exp_acc) begin
      term_q <= quot[32:0];
      sum_q  <= (neg_q && k_q[0]) ? sum_q - qext : sum_q + qext;
      k_q    <= k_q + 1'b1;
    end
    if (cmd_i.exp_end) begin
      acc_q <= clampv;
    end
    if (cmd_i.pexp_wb) begin
      acc_q <= prod_q[65:32];
    end
    if (cmd_i.whole_wb) begin
      acc_q <= neg_q ? prod_q[65:32] : prod_q[63:30];
      n_q   <= n_q - 1'b1;
    end
    if (cmd_i.set_a) begin
      a_q <= 33'h1_0000_0000 - acc_q[32:0];
    end
    if (cmd_i.set_w) begin
      w_q <= (acc_q >= 34'h0_4000_0000) ? W_MAX : acc_q[29:6];
    end
    if (cmd_i.clr_w) begin
      w_q <= '0;
    end
    if (cmd_i.sh_zero) begin
      lf_q <= '0;
      rf_q <= '0;
    end
    if (cmd_i.set_lf) begin
      lf_q <= quot[16:0];
    end
    if (cmd_i.set_rf) begin
      rf_q <= quot[16:0];
    end
    if (cmd_i.w_raw) begin
      w_q <= w_rd_q;
    end
    if (cmd_i.w_div) begin
      w_q <= (quot[55:24] != '0) ? W_MAX : quot[23:0];
    end
    if (cmd_i.acc_hi) begin
      r_q <= 49'(prod_q[47:0]);
    end
    if (cmd_i.acc_lo) begin
      r_q <= r_lo_sum;
    end
    if (cmd_i.set_lm) begin
      lm_q <= r_lo_sum[47:0];
    end
    if (cmd_i.set_rc) begin
      rc_q <= rpres_q ? sat48(rc_diff) : '0;
    end
    if (cmd_i.sh_hi) begin
      r_q <= {prod_q[40:0], 8'h0};
    end
    if (cmd_i.set_lc) begin
      lc_q <= lpres_q ? sat48(s_sig) : '0;
    end
    if (cmd_i.set_fc) begin
      fc_q <= fpres_q ? sat48(s_sig) : '0;
    end
  end

  always_comb begin
    sts_o.full     = loaded_q == CNT_W'(MAX_LAYERS);
    sts_o.zero_w   = (efold_q == '0) || span_q[31] || (span_q == '0);
    sts_o.div_done = div_done;
    sts_o.k_last   = k_q == EXP_TERMS;
    sts_o.whole_go = (n_q != '0) && (acc_q != '0) &&
                     (neg_q || (acc_q < 34'h0_4000_0000));
    sts_o.a_zero   = a_q == '0;
    sts_o.last     = last_q;
    sts_o.tot_zero = tot == '0;
    sts_o.norm_go  = norm_q && (total_q != '0);
    sts_o.out_last = (i_q + 1'b1) == loaded_q;
  end

  assign layer_number_o      = LAYER_W'(i_q);
  assign root_change_o       = rc_q;
  assign labile_change_o     = lc_q;
  assign refractory_change_o = fc_q;
  assign run_end_o           = sts_o.out_last;

endmodule

### src/adep_ctrl.sv
module adep_ctrl
  import adep_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic out_valid_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_CHECK = 6'd1;
  localparam logic [5:0] S_RGO   = 6'd2;
  localparam logic [5:0] S_RWAIT = 6'd3;
  localparam logic [5:0] S_EMUL  = 6'd4;
  localparam logic [5:0] S_EDGO  = 6'd5;
  localparam logic [5:0] S_EDWT  = 6'd6;
  localparam logic [5:0] S_EEND  = 6'd7;
  localparam logic [5:0] S_PWB   = 6'd8;
  localparam logic [5:0] S_WHOLE = 6'd9;
  localparam logic [5:0] S_WWB   = 6'd10;
  localparam logic [5:0] S_ACHK  = 6'd11;
  localparam logic [5:0] S_STORE = 6'd12;
  localparam logic [5:0] S_LCHK  = 6'd13;
  localparam logic [5:0] S_SH1W  = 6'd14;
  localparam logic [5:0] S_SH2G  = 6'd15;
  localparam logic [5:0] S_SH2W  = 6'd16;
  localparam logic [5:0] S_ERD   = 6'd17;
  localparam logic [5:0] S_ENRM  = 6'd18;
  localparam logic [5:0] S_ENW   = 6'd19;
  localparam logic [5:0] S_EBH   = 6'd20;
  localparam logic [5:0] S_EBL   = 6'd21;
  localparam logic [5:0] S_ERSUM = 6'd22;
  localparam logic [5:0] S_ERC   = 6'd23;
  localparam logic [5:0] S_EML   = 6'd24;
  localparam logic [5:0] S_ELSUM = 6'd25;
  localparam logic [5:0] S_ELH   = 6'd26;
  localparam logic [5:0] S_ELL   = 6'd27;
  localparam logic [5:0] S_ELC   = 6'd28;
  localparam logic [5:0] S_EFH   = 6'd29;
  localparam logic [5:0] S_EFL   = 6'd30;
  localparam logic [5:0] S_EFC   = 6'd31;
  localparam logic [5:0] S_EOUT  = 6'd32;

  logic [5:0] state_q, state_d;
  logic       phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        phase_d = 1'b0;
        if (sts_i.full) begin
          state_d = S_LCHK;
        end else if (sts_i.zero_w) begin
          cmd_o.clr_w = 1'b1;
          state_d     = S_STORE;
        end else begin
          state_d = S_RGO;
        end
      end
      S_RGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_RATIO;
        state_d       = S_RWAIT;
      end
      S_RWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.exp_init = 1'b1;
          state_d        = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd_o.mul_sel = MUL_TERM;
        state_d       = S_EDGO;
      end
      S_EDGO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_EXP;
        state_d       = S_EDWT;
      end
      S_EDWT: begin
        if (sts_i.div_done) begin
          cmd_o.exp_acc = 1'b1;
          state_d       = sts_i.k_last ? S_EEND : S_EMUL;
        end
      end
      S_EEND: begin
        if (phase_q) begin
          cmd_o.mul_sel = MUL_PEXP;
          state_d       = S_PWB;
        end else begin
          cmd_o.exp_end = 1'b1;
          state_d       = S_WHOLE;
        end
      end
      S_PWB: begin
        cmd_o.pexp_wb = 1'b1;
        state_d       = S_WHOLE;
      end
      S_WHOLE: begin
        if (sts_i.whole_go) begin
          cmd_o.mul_sel = MUL_WHOLE;
          state_d       = S_WWB;
        end else if (phase_q) begin
          cmd_o.set_w = 1'b1;
          state_d     = S_STORE;
        end else begin
          cmd_o.set_a = 1'b1;
          state_d     = S_ACHK;
        end
      end
      S_WWB: begin
        cmd_o.whole_wb = 1'b1;
        state_d        = S_WHOLE;
      end
      S_ACHK: begin
        if (sts_i.a_zero) begin
          cmd_o.clr_w = 1'b1;
          state_d     = S_STORE;
        end else begin
          phase_d = 1'b1;
          state_d = S_RGO;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_LCHK;
      end
      S_LCHK: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.tot_zero) begin
          cmd_o.sh_zero = 1'b1;
          state_d       = S_ERD;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DIV_SHL;
          state_d       = S_SH1W;
        end
      end
      S_SH1W: begin
        if (sts_i.div_done) begin
          cmd_o.set_lf = 1'b1;
          state_d      = S_SH2G;
        end
      end
      S_SH2G: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_SHR;
        state_d       = S_SH2W;
      end
      S_SH2W: begin
        if (sts_i.div_done) begin
          cmd_o.set_rf = 1'b1;
          state_d      = S_ERD;
        end
      end
      S_ERD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ENRM;
      end
      S_ENRM: begin
        if (sts_i.norm_go) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DIV_NORM;
          state_d       = S_ENW;
        end else begin
          cmd_o.w_raw = 1'b1;
          state_d     = S_EBH;
        end
      end
      S_ENW: begin
        if (sts_i.div_done) begin
          cmd_o.w_div = 1'b1;
          state_d     = S_EBH;
        end
      end
      S_EBH: begin
        cmd_o.mul_sel = MUL_BH;
        state_d       = S_EBL;
      end
      S_EBL: begin
        cmd_o.mul_sel = MUL_BL;
        cmd_o.acc_hi  = 1'b1;
        state_d       = S_ERSUM;
      end
      S_ERSUM: begin
        cmd_o.acc_lo = 1'b1;
        state_d      = S_ERC;
      end
      S_ERC: begin
        cmd_o.set_rc  = 1'b1;
        cmd_o.mul_sel = MUL_MH;
        state_d       = S_EML;
      end
      S_EML: begin
        cmd_o.mul_sel = MUL_ML;
        cmd_o.acc_hi  = 1'b1;
        state_d       = S_ELSUM;
      end
      S_ELSUM: begin
        cmd_o.set_lm = 1'b1;
        state_d      = S_ELH;
      end
      S_ELH: begin
        cmd_o.mul_sel = MUL_LH;
        state_d       = S_ELL;
      end
      S_ELL: begin
        cmd_o.mul_sel = MUL_LL;
        cmd_o.sh_hi   = 1'b1;
        state_d       = S_ELC;
      end
      S_ELC: begin
        cmd_o.set_lc = 1'b1;
        state_d      = S_EFH;
      end
      S_EFH: begin
        cmd_o.mul_sel = MUL_FH;
        state_d       = S_EFL;
      end
      S_EFL: begin
        cmd_o.mul_sel = MUL_FL;
        cmd_o.sh_hi   = 1'b1;
        state_d       = S_EFC;
      end
      S_EFC: begin
        cmd_o.set_fc = 1'b1;
        state_d      = S_EOUT;
      end
      S_EOUT: begin
        cmd_o.advance = 1'b1;
        state_d       = sts_i.out_last ? S_IDLE : S_ERD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy        = state_q != S_IDLE;
  assign out_valid_o = state_q == S_EOUT;

endmodule

### src/exp_depth_root_allocation.sv
// Exponential depth root allocation.
//
// A column is loaded one layer word at a time: pulse start while busy is low
// and the layer's elevations, thickness and masses are taken at that edge.
// For each layer the block forms the depth weight and stores it with the
// layer's current root mass. The word flagged final_layer closes the column:
// the block then emits one result word per stored layer, in layer order, each
// on the result ports for exactly one cycle with out_valid_o high, the last
// one with run_end_o set. Results cannot be held off by the receiver.
// Loading a layer needs up to two exponentials. Each one is a ratio
// division followed by thirteen series terms, each of which waits on the
// same bit-serial 56-step divider, and then one multiply per whole
// e-folding unit. A layer whose weight is zero by rule, or one that arrives
// with the store full, is done without any division. Closing a column adds
// two share divisions unless both shares are zero. Each layer's output then
// adds a division if renormalization is on and the weight sum is positive.
// Reset loads the register defaults and empties the column; no clearing pass
// runs. Configuration writes are taken at once and belong to idle periods.

module exp_depth_root_allocation
  import adep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] surface_level_i,
  input  logic signed [31:0] layer_top_level_i,
  input  logic signed [31:0] layer_depth_span_i,
  input  logic signed [47:0] root_mass_now_i,
  input  logic signed [47:0] standing_biomass_i,
  input  logic signed [47:0] mortality_flux_i,
  input  logic               final_layer_i,
  output logic               out_valid_o,
  output logic [5:0]         layer_number_o,
  output logic signed [47:0] root_change_o,
  output logic signed [47:0] labile_change_o,
  output logic signed [47:0] refractory_change_o,
  output logic               run_end_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences every step; the datapath owns all arithmetic,
  // the layer stores and the shared divider.
  adep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  adep_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .surface_level_i     (surface_level_i),
    .layer_top_level_i   (layer_top_level_i),
    .layer_depth_span_i  (layer_depth_span_i),
    .root_mass_now_i     (root_mass_now_i),
    .standing_biomass_i  (standing_biomass_i),
    .mortality_flux_i    (mortality_flux_i),
    .final_layer_i       (final_layer_i),
    .layer_number_o      (layer_number_o),
    .root_change_o       (root_change_o),
    .labile_change_o     (labile_change_o),
    .refractory_change_o (refractory_change_o),
    .run_end_o           (run_end_o)
  );

endmodule
